### src/assert_macros.svh
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/dtg_pkg.sv
// Shared types, codes and constants of the double-tap gesture detector.
`default_nettype none

package dtg_pkg;

	// Field widths
	localparam int COORD_BITS  = 12;
	localparam int TIME_BITS   = 32;
	localparam int FINGER_BITS = 16;
	localparam int RADIUS_BITS = 12;
	localparam int MS_BITS     = 16;
	localparam int CMD_BITS    = 2;

	// Squared-distance compare widths
	localparam int DIST_BITS = 2 * COORD_BITS + 1;
	localparam int R2_BITS   = 2 * RADIUS_BITS;
	localparam int CMP_BITS  = (DIST_BITS > R2_BITS) ? DIST_BITS : R2_BITS;

	// Event kinds
	localparam logic [CMD_BITS-1:0] CMD_DOWN   = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_MOTION = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_UP     = 2'd2;

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MOVE_RADIUS = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TAP_RADIUS  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TAP_MS  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_GAP_MS  = 3'd4;

	// Register reset values
	localparam int MOVE_RADIUS_RST = 24;
	localparam int TAP_RADIUS_RST  = 38;
	localparam int MAX_TAP_MS_RST  = 220;
	localparam int MAX_GAP_MS_RST  = 320;
	localparam logic [R2_BITS-1:0] MOVE_R2_RST = R2_BITS'(MOVE_RADIUS_RST * MOVE_RADIUS_RST);
	localparam logic [R2_BITS-1:0] TAP_R2_RST  = R2_BITS'(TAP_RADIUS_RST * TAP_RADIUS_RST);

	typedef struct packed {
		logic [CMD_BITS-1:0]    cmd;
		logic [FINGER_BITS-1:0] finger_id;
		logic [COORD_BITS-1:0]  x_px;
		logic [COORD_BITS-1:0]  y_px;
		logic [TIME_BITS-1:0]   time_ms;
		logic                   gameplay_mode;
		logic                   message_shown;
		logic                   suppress;
	} evt_t;

	typedef struct packed {
		logic fire;
		logic armed;
		logic tracking;
	} res_t;

	typedef struct packed {
		logic [CFG_IDX_BITS-1:0]  index;
		logic [CFG_DATA_BITS-1:0] data;
	} cfg_t;

endpackage

`default_nettype wire

### src/double_tap_gesture_detector.sv
// Double-tap gesture detector: event input stage, tap tracking state and result register.
//
// Usage:
//   evt channel (evt_valid/evt_ready/evt): one touch event per transfer, kind down,
//   motion or up, with finger id, pixel position, timestamp and host flags.
//   res channel (res_valid/res_ready/res): exactly one result per event, in order:
//   fire (this down completed a double tap), armed and tracking after the event.
//   cfg channel (cfg_valid/cfg_ready/cfg): register writes, always ready; write only
//   while no event is in flight. Unknown indexes are dropped.
// Path: the input stage holds each accepted event; its result is then registered in the result register.
// Throughput: one event per cycle while the result side is not stalled; the input stage
//   and the result register each hold one item, and the combinational distance/time
//   compare on the input stage sets that figure.
// Reset: clears the detector, empties both stages, loads the register defaults
//   (disabled, move radius 24, tap radius 38, tap 220 ms, gap 320 ms).
// Stall: while res_ready is low the result holds; one further event is taken into
//   the input stage, then evt_ready drops until the result is transferred.
`default_nettype none

module double_tap_gesture_detector (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          evt_valid,
	output logic               evt_ready,
	input  wire dtg_pkg::evt_t evt,
	output logic               res_valid,
	input  wire logic          res_ready,
	output dtg_pkg::res_t      res,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire dtg_pkg::cfg_t cfg
);
	import dtg_pkg::*;

	// Configuration registers (radii kept squared)
	logic               enable_q;
	logic [R2_BITS-1:0] move_r2_q;
	logic [R2_BITS-1:0] tap_r2_q;
	logic [MS_BITS-1:0] max_tap_q;
	logic [MS_BITS-1:0] max_gap_q;

	// Detector state
	logic                   cand_active_q;
	logic                   moved_far_q;
	logic                   tap_armed_q;
	logic [FINGER_BITS-1:0] cand_finger_q;
	logic [COORD_BITS-1:0]  cand_x_q, cand_y_q, tap_x_q, tap_y_q;
	logic [TIME_BITS-1:0]   cand_time_q, tap_time_q;

	// Pipeline
	logic valid_s1;
	evt_t evt_s1;
	logic res_valid_q;
	res_t res_q;
	logic advance;

	// Compute signals
	logic [COORD_BITS-1:0] ref_x, ref_y, dx, dy;
	logic [R2_BITS-1:0]    r2_sel;
	logic [DIST_BITS-1:0]  dist2;
	logic                  near;
	logic [TIME_BITS-1:0]  gap_el, press_el;
	logic                  gap_ok, press_ok, same_finger, is_tap;
	logic                  cand_active_d, moved_far_d, tap_armed_d, fire_d;
	logic                  start_cand, arm_tap;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			move_r2_q <= MOVE_R2_RST;
			tap_r2_q  <= TAP_R2_RST;
			max_tap_q <= MS_BITS'(MAX_TAP_MS_RST);
			max_gap_q <= MS_BITS'(MAX_GAP_MS_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg.index)
				REG_ENABLE:      enable_q  <= cfg.data[0];
				REG_MOVE_RADIUS: move_r2_q <= R2_BITS'(cfg.data[RADIUS_BITS-1:0])
					* R2_BITS'(cfg.data[RADIUS_BITS-1:0]);
				REG_TAP_RADIUS:  tap_r2_q  <= R2_BITS'(cfg.data[RADIUS_BITS-1:0])
					* R2_BITS'(cfg.data[RADIUS_BITS-1:0]);
				REG_MAX_TAP_MS:  max_tap_q <= cfg.data[MS_BITS-1:0];
				REG_MAX_GAP_MS:  max_gap_q <= cfg.data[MS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Shared distance check: tap point on a down, candidate start otherwise
	always_comb begin
		if (evt_s1.cmd == CMD_DOWN) begin
			ref_x  = tap_x_q;
			ref_y  = tap_y_q;
			r2_sel = tap_r2_q;
		end else begin
			ref_x  = cand_x_q;
			ref_y  = cand_y_q;
			r2_sel = move_r2_q;
		end
		dx = (ref_x > evt_s1.x_px) ? ref_x - evt_s1.x_px : evt_s1.x_px - ref_x;
		dy = (ref_y > evt_s1.y_px) ? ref_y - evt_s1.y_px : evt_s1.y_px - ref_y;
		dist2 = DIST_BITS'(DIST_BITS'(dx) * DIST_BITS'(dx))
			+ DIST_BITS'(DIST_BITS'(dy) * DIST_BITS'(dy));
		near = CMP_BITS'(dist2) <= CMP_BITS'(r2_sel);
	end

	// Elapsed times, modulo the timestamp width
	assign gap_el      = evt_s1.time_ms - tap_time_q;
	assign press_el    = evt_s1.time_ms - cand_time_q;
	assign gap_ok      = gap_el <= TIME_BITS'(max_gap_q);
	assign press_ok    = press_el <= TIME_BITS'(max_tap_q);
	assign same_finger = cand_active_q && (cand_finger_q == evt_s1.finger_id);
	assign is_tap      = evt_s1.gameplay_mode && !evt_s1.message_shown && press_ok
		&& !moved_far_q && near;

	// Next detector state
	always_comb begin
		cand_active_d = cand_active_q;
		moved_far_d   = moved_far_q;
		tap_armed_d   = tap_armed_q;
		fire_d        = 1'b0;
		start_cand    = 1'b0;
		arm_tap       = 1'b0;
		unique case (evt_s1.cmd)
			CMD_DOWN: begin
				if (!enable_q || !evt_s1.gameplay_mode || evt_s1.suppress) begin
					cand_active_d = 1'b0;
					moved_far_d   = 1'b0;
					tap_armed_d   = 1'b0;
				end else if (tap_armed_q && gap_ok && near) begin
					tap_armed_d   = 1'b0;
					cand_active_d = 1'b0;
					fire_d        = 1'b1;
				end else begin
					tap_armed_d   = 1'b0;
					cand_active_d = 1'b1;
					moved_far_d   = 1'b0;
					start_cand    = 1'b1;
				end
			end
			CMD_MOTION: begin
				if (evt_s1.gameplay_mode && enable_q && same_finger && !near)
					moved_far_d = 1'b1;
			end
			CMD_UP: begin
				if (!enable_q) begin
					cand_active_d = 1'b0;
					moved_far_d   = 1'b0;
					tap_armed_d   = 1'b0;
				end else if (same_finger) begin
					cand_active_d = 1'b0;
					tap_armed_d   = is_tap;
					arm_tap       = is_tap;
				end
			end
			default: ;
		endcase
	end

	// Control registers: stage valids, detector flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			res_valid_q   <= 1'b0;
			cand_active_q <= 1'b0;
			moved_far_q   <= 1'b0;
			tap_armed_q   <= 1'b0;
		end else begin
			if (evt_ready)
				valid_s1 <= evt_valid;
			if (advance) begin
				res_valid_q   <= 1'b1;
				cand_active_q <= cand_active_d;
				moved_far_q   <= moved_far_d;
				tap_armed_q   <= tap_armed_d;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready)
			evt_s1 <= evt;
		if (advance) begin
			res_q.fire     <= fire_d;
			res_q.armed    <= tap_armed_d;
			res_q.tracking <= cand_active_d;
			if (start_cand) begin
				cand_finger_q <= evt_s1.finger_id;
				cand_x_q      <= evt_s1.x_px;
				cand_y_q      <= evt_s1.y_px;
				cand_time_q   <= evt_s1.time_ms;
			end
			if (arm_tap) begin
				tap_x_q    <= evt_s1.x_px;
				tap_y_q    <= evt_s1.y_px;
				tap_time_q <= evt_s1.time_ms;
			end
		end
	end

endmodule

`default_nettype wire

### src/dtg_checker.sv
// Port-level checker for the double-tap gesture detector, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module dtg_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          evt_valid,
	input wire logic          evt_ready,
	input wire dtg_pkg::evt_t evt,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire dtg_pkg::res_t res,
	input wire logic          cfg_valid,
	input wire logic          cfg_ready,
	input wire dtg_pkg::cfg_t cfg
);
	import dtg_pkg::*;

	// A stalled result holds until its transfer
	`ASSERT_CLK(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable(res), "result changed while stalled")
	// A firing down leaves neither an armed tap nor a tracked press
	`ASSERT_CLK(a_fire_clears, clk, arst_n, res_valid && res.fire |-> !res.armed && !res.tracking, "fire with armed or tracking set")
	// An armed tap and a tracked press never coexist
	`ASSERT_CLK(a_arm_track_excl, clk, arst_n, res_valid |-> !(res.armed && res.tracking), "armed and tracking both set")
	// With the result register empty the input side is never blocked
	`ASSERT_CLK(a_ready_when_empty, clk, arst_n, !res_valid |-> evt_ready && cfg_ready, "input blocked with empty output")

endmodule

bind double_tap_gesture_detector dtg_checker u_dtg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt_valid),
	.evt_ready (evt_ready),
	.evt       (evt),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg       (cfg)
);

`default_nettype wire

### tb/dtg_checker.sv
// Scoreboard for the double-tap detector: tracks register writes, predicts each result, compares.
module dtg_scoreboard (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          evt_valid,
	input  wire logic          evt_ready,
	input  wire dtg_pkg::evt_t evt,
	input  wire logic          res_valid,
	input  wire logic          res_ready,
	input  wire dtg_pkg::res_t res,
	input  wire logic          cfg_valid,
	input  wire logic          cfg_ready,
	input  wire dtg_pkg::cfg_t cfg,
	output int                 error_count,
	output int                 results_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import dtg_pkg::*;

	// Shadow copy of the register file
	logic                   det_en;
	logic [RADIUS_BITS-1:0] move_rad;
	logic [RADIUS_BITS-1:0] tap_rad;
	logic [MS_BITS-1:0]     tap_limit_ms;
	logic [MS_BITS-1:0]     gap_limit_ms;

	// Shadow copy of the gesture state
	logic                   cand_on;
	logic [FINGER_BITS-1:0] cand_fid;
	logic [COORD_BITS-1:0]  cand_px;
	logic [COORD_BITS-1:0]  cand_py;
	logic [TIME_BITS-1:0]   cand_stamp;
	logic                   strayed;
	logic                   tap_on;
	logic [COORD_BITS-1:0]  tap_px;
	logic [COORD_BITS-1:0]  tap_py;
	logic [TIME_BITS-1:0]   tap_stamp;

	// Predicted results waiting for their transfer, oldest first
	res_t expected_flags[$];

	// Exact squared-distance test, no rounding
	function automatic bit in_reach(input longint unsigned ax, ay, bx, by, r);
		longint unsigned dx, dy;
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		return dx * dx + dy * dy <= r * r;
	endfunction

	task automatic drop_gesture();
		cand_on    = 1'b0;
		cand_fid   = '0;
		cand_px    = '0;
		cand_py    = '0;
		cand_stamp = '0;
		strayed    = 1'b0;
		tap_on     = 1'b0;
		tap_px     = '0;
		tap_py     = '0;
		tap_stamp  = '0;
	endtask

	// Advance the shadow state by one touch event and return the flags it yields
	task automatic track_touch(input evt_t e, output res_t flags);
		logic [TIME_BITS-1:0] since;
		bit                   quick_tap;
		flags = '0;
		case (e.cmd)
			CMD_DOWN: begin
				since = e.time_ms - tap_stamp;
				if (!det_en || !e.gameplay_mode || e.suppress) begin
					drop_gesture();
				end else if (tap_on && since <= gap_limit_ms &&
						in_reach(tap_px, tap_py, e.x_px, e.y_px, tap_rad)) begin
					tap_on     = 1'b0;
					cand_on    = 1'b0;
					flags.fire = 1'b1;
				end else begin
					tap_on     = 1'b0;
					cand_on    = 1'b1;
					cand_fid   = e.finger_id;
					cand_px    = e.x_px;
					cand_py    = e.y_px;
					cand_stamp = e.time_ms;
					strayed    = 1'b0;
				end
			end
			CMD_MOTION: begin
				if (e.gameplay_mode && det_en && cand_on && cand_fid == e.finger_id &&
						!in_reach(cand_px, cand_py, e.x_px, e.y_px, move_rad))
					strayed = 1'b1;
			end
			CMD_UP: begin
				since = e.time_ms - cand_stamp;
				if (!det_en) begin
					drop_gesture();
				end else if (cand_on && cand_fid == e.finger_id) begin
					quick_tap = e.gameplay_mode && !e.message_shown &&
						since <= tap_limit_ms && !strayed &&
						in_reach(cand_px, cand_py, e.x_px, e.y_px, move_rad);
					cand_on = 1'b0;
					tap_on  = quick_tap;
					if (quick_tap) begin
						tap_px    = e.x_px;
						tap_py    = e.y_px;
						tap_stamp = e.time_ms;
					end
				end
			end
			default: ;
		endcase
		flags.armed    = tap_on;
		flags.tracking = cand_on;
	endtask

	// Everything is sampled on the rising edge, before the block's own updates land
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			det_en       = 1'b0;
			move_rad     = RADIUS_BITS'(MOVE_RADIUS_RST);
			tap_rad      = RADIUS_BITS'(TAP_RADIUS_RST);
			tap_limit_ms = MS_BITS'(MAX_TAP_MS_RST);
			gap_limit_ms = MS_BITS'(MAX_GAP_MS_RST);
			drop_gesture();
			expected_flags.delete();
			error_count = 0;
		end else begin
			// result transfer: match against the oldest prediction
			if (res_valid && res_ready) begin
				if (expected_flags.size() == 0) begin
					$error("result %p with no event outstanding", res);
					error_count++;
				end else begin
					want = expected_flags.pop_front();
					if (res.fire !== want.fire) begin
						$error("fire: expected %0b, got %0b", want.fire, res.fire);
						error_count++;
					end
					if (res.armed !== want.armed) begin
						$error("armed: expected %0b, got %0b", want.armed, res.armed);
						error_count++;
					end
					if (res.tracking !== want.tracking) begin
						$error("tracking: expected %0b, got %0b", want.tracking, res.tracking);
						error_count++;
					end
				end
			end
			// register write; unknown indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg.index)
					REG_ENABLE:      det_en       = cfg.data[0];
					REG_MOVE_RADIUS: move_rad     = cfg.data[RADIUS_BITS-1:0];
					REG_TAP_RADIUS:  tap_rad      = cfg.data[RADIUS_BITS-1:0];
					REG_MAX_TAP_MS:  tap_limit_ms = cfg.data[MS_BITS-1:0];
					REG_MAX_GAP_MS:  gap_limit_ms = cfg.data[MS_BITS-1:0];
					default: ;
				endcase
			end
			// event transfer: one prediction per event
			if (evt_valid && evt_ready) begin
				track_touch(evt, want);
				expected_flags.push_back(want);
			end
		end
		results_pending = expected_flags.size();
	end

endmodule

### tb/tb.sv
// Top of the double-tap detector testbench: clock, reset, touch stimulus, register phases, verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dtg_pkg::*;

	// Event kind the block has no use for, and the first index past the register file
	localparam logic [CMD_BITS-1:0]     CMD_UNUSED       = 2'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_UNUSED = 3'd5;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_ready;
	evt_t evt       = '0;
	logic res_valid;
	logic res_ready = 1'b1;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_t cfg       = '0;

	int error_count;
	int results_pending;

	// Stimulus bookkeeping
	bit idle_on    = 1'b1;
	int items_sent = 0;
	int cur_move   = MOVE_RADIUS_RST;
	int cur_tap    = TAP_RADIUS_RST;
	int cur_tap_ms = MAX_TAP_MS_RST;
	int cur_gap_ms = MAX_GAP_MS_RST;

	double_tap_gesture_detector u_top (
		.clk, .arst_n,
		.evt_valid, .evt_ready, .evt,
		.res_valid, .res_ready, .res,
		.cfg_valid, .cfg_ready, .cfg
	);

	dtg_scoreboard u_checker (
		.clk, .arst_n,
		.evt_valid, .evt_ready, .evt,
		.res_valid, .res_ready, .res,
		.cfg_valid, .cfg_ready, .cfg,
		.error_count, .results_pending
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: random back-pressure unless idling is switched off
	always @(negedge clk) begin
		res_ready = !idle_on || ($urandom_range(99) >= 14);
	end

	function automatic bit chance(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic evt_t touch(input logic [CMD_BITS-1:0] kind,
			input logic [FINGER_BITS-1:0] fid, input int x, input int y,
			input logic [TIME_BITS-1:0] stamp, input bit game, msg, sup);
		evt_t e;
		e.cmd           = kind;
		e.finger_id     = fid;
		e.x_px          = COORD_BITS'(x);
		e.y_px          = COORD_BITS'(y);
		e.time_ms       = stamp;
		e.gameplay_mode = game;
		e.message_shown = msg;
		e.suppress      = sup;
		return e;
	endfunction

	// Coordinate around c, spread up to just past radius r or up to half of it, clamped to the screen
	function automatic int near(input int c, input int r);
		int span;
		int v;
		span = chance(50) ? r + 2 : r / 2;
		v = c - span + int'($urandom_range(2 * span));
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v;
	endfunction

	// One event transfer, with random idle cycles ahead of it; valid stays high afterward
	task automatic send_event(input evt_t e);
		@(negedge clk);
		while (idle_on && chance(14)) begin
			evt_valid = 1'b0;
			@(negedge clk);
		end
		evt       = e;
		evt_valid = 1'b1;
		do @(posedge clk); while (!evt_ready);
		items_sent++;
	endtask

	// Stop sending and wait for every outstanding result, bounded
	task automatic drain();
		int waited;
		@(negedge clk);
		evt_valid = 1'b0;
		for (waited = 0; waited < 5000 && results_pending != 0; waited++)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid  = 1'b1;
		cfg.index  = idx;
		cfg.data   = data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Full register setting, written only with the block idle; junk in unused data bits
	task automatic configure(input bit en, input int mv, tp, tms, gms);
		drain();
		write_reg(REG_ENABLE, {15'($urandom), en});
		write_reg(REG_MOVE_RADIUS, {4'($urandom), 12'(mv)});
		write_reg(REG_TAP_RADIUS, {4'($urandom), 12'(tp)});
		write_reg(REG_MAX_TAP_MS, 16'(tms));
		write_reg(REG_MAX_GAP_MS, 16'(gms));
		write_reg(REG_FIRST_UNUSED + CFG_IDX_BITS'($urandom_range(2)), 16'($urandom));
		@(negedge clk);
		cfg_valid  = 1'b0;
		cur_move   = mv & 12'hFFF;
		cur_tap    = tp & 12'hFFF;
		cur_tap_ms = tms & 16'hFFFF;
		cur_gap_ms = gms & 16'hFFFF;
	endtask

	// Mostly well-formed press, lift and second press, each step nudged across its limit
	task automatic double_tap_try();
		logic [FINGER_BITS-1:0] fid;
		logic [TIME_BITS-1:0]   stamp;
		int x0, y0, x1, y1, x2, y2;
		int moves;
		fid   = chance(25) ? FINGER_BITS'($urandom) : FINGER_BITS'($urandom_range(3));
		x0    = $urandom_range(4095);
		y0    = $urandom_range(4095);
		stamp = chance(10) ? 32'hFFFF_FFFF - $urandom_range(300) : 32'($urandom);
		send_event(touch(CMD_DOWN, fid, x0, y0, stamp, chance(95), chance(10), chance(5)));
		moves = $urandom_range(3);
		repeat (moves) begin
			x1    = near(x0, cur_move);
			y1    = near(y0, cur_move);
			stamp = stamp + $urandom_range(40);
			send_event(touch(CMD_MOTION, chance(90) ? fid : FINGER_BITS'($urandom), x1, y1,
				stamp, chance(95), chance(50), chance(50)));
		end
		x1    = near(x0, cur_move);
		y1    = near(y0, cur_move);
		stamp = stamp + $urandom_range(cur_tap_ms + cur_tap_ms / 8 + 2);
		send_event(touch(CMD_UP, chance(92) ? fid : FINGER_BITS'($urandom), x1, y1, stamp,
			chance(95), chance(10), chance(50)));
		x2    = near(x1, cur_tap);
		y2    = near(y1, cur_tap);
		stamp = stamp + $urandom_range(cur_gap_ms + cur_gap_ms / 8 + 2);
		fid   = FINGER_BITS'($urandom);
		send_event(touch(CMD_DOWN, fid, x2, y2, stamp, chance(95), chance(10), chance(5)));
		if (chance(50)) begin
			stamp = stamp + $urandom_range(cur_tap_ms + 2);
			send_event(touch(CMD_UP, fid, near(x2, cur_move), near(y2, cur_move), stamp,
				chance(95), chance(10), chance(50)));
		end
	endtask

	// Random traffic up to a running item count: gestures with some raw noise mixed in
	task automatic run_random(input int upto);
		while (items_sent < upto) begin
			if (chance(80))
				double_tap_try();
			else
				send_event(touch(CMD_BITS'($urandom), FINGER_BITS'($urandom),
					$urandom_range(4095), $urandom_range(4095), 32'($urandom),
					chance(50), chance(50), chance(50)));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// disabled out of reset: down and up both clear
		send_event(touch(CMD_DOWN, 16'd1, 100, 100, 32'd10, 1, 0, 0));
		send_event(touch(CMD_UP, 16'd1, 100, 100, 32'd20, 1, 0, 0));
		configure(1, MOVE_RADIUS_RST, TAP_RADIUS_RST, MAX_TAP_MS_RST, MAX_GAP_MS_RST);
		// down outside gameplay, then a suppressed down
		send_event(touch(CMD_DOWN, 16'd7, 100, 100, 32'd900, 0, 0, 0));
		send_event(touch(CMD_DOWN, 16'd7, 100, 100, 32'd950, 1, 0, 1));
		// tap held at the exact limits, ignored motions and a foreign lift in between
		send_event(touch(CMD_DOWN, 16'd7, 100, 100, 32'd1000, 1, 0, 0));
		send_event(touch(CMD_MOTION, 16'd7, 500, 500, 32'd1010, 0, 0, 0));
		send_event(touch(CMD_MOTION, 16'd8, 500, 500, 32'd1020, 1, 0, 0));
		send_event(touch(CMD_UP, 16'd8, 100, 100, 32'd1030, 1, 0, 0));
		send_event(touch(CMD_UP, 16'd7, 110, 110, 32'd1220, 1, 0, 0));
		send_event(touch(CMD_DOWN, 16'd9, 148, 110, 32'd1540, 1, 0, 0));
		// finger strays one pixel past the move radius
		send_event(touch(CMD_DOWN, 16'd7, 0, 4095, 32'd2000, 1, 0, 0));
		send_event(touch(CMD_MOTION, 16'd7, 25, 4095, 32'd2005, 1, 0, 0));
		send_event(touch(CMD_UP, 16'd7, 0, 4095, 32'd2010, 1, 0, 0));
		// timestamp wrap, lift under a message, then a press one ms too long
		send_event(touch(CMD_DOWN, 16'hFFFF, 4095, 0, 32'hFFFF_FFF0, 1, 0, 0));
		send_event(touch(CMD_UP, 16'hFFFF, 4095, 0, 32'h0000_0010, 1, 1, 0));
		send_event(touch(CMD_DOWN, 16'hFFFF, 4095, 0, 32'h0000_0020, 1, 0, 0));
		send_event(touch(CMD_UP, 16'hFFFF, 4095, 0, 32'h0000_00FD, 1, 0, 0));
		// armed, second down one ms late, then a lift past the move radius
		send_event(touch(CMD_DOWN, 16'd3, 2000, 2000, 32'd5000, 1, 0, 0));
		send_event(touch(CMD_UP, 16'd3, 2000, 2000, 32'd5100, 1, 0, 0));
		send_event(touch(CMD_DOWN, 16'd3, 2000, 2000, 32'd5421, 1, 0, 0));
		send_event(touch(CMD_UP, 16'd3, 2025, 2000, 32'd5500, 1, 0, 0));
		send_event(touch(CMD_UNUSED, 16'd3, 2000, 2000, 32'd5600, 1, 0, 0));
		// armed, second down one pixel beyond the tap radius
		send_event(touch(CMD_DOWN, 16'd4, 50, 50, 32'd6000, 1, 0, 0));
		send_event(touch(CMD_UP, 16'd4, 50, 50, 32'd6000, 1, 0, 0));
		send_event(touch(CMD_DOWN, 16'd5, 89, 50, 32'd6001, 1, 0, 0));
		// disabling: an up clears everything
		configure(0, MOVE_RADIUS_RST, TAP_RADIUS_RST, MAX_TAP_MS_RST, MAX_GAP_MS_RST);
		send_event(touch(CMD_UP, 16'd5, 89, 50, 32'd6002, 1, 0, 0));

		// random phases over several register settings
		configure(1, MOVE_RADIUS_RST, TAP_RADIUS_RST, MAX_TAP_MS_RST, MAX_GAP_MS_RST);
		run_random(250);
		configure(1, 0, 0, 0, 0);
		run_random(400);
		configure(1, 4095, 4095, 65535, 65535);
		idle_on = 1'b0;
		run_random(550);
		idle_on = 1'b1;
		configure(1, $urandom_range(1, 200), $urandom_range(1, 300), $urandom_range(1, 2000),
			$urandom_range(1, 3000));
		run_random(750);
		configure(0, $urandom_range(4095), $urandom_range(4095), $urandom_range(65535),
			$urandom_range(65535));
		run_random(830);
		configure(1, $urandom_range(4095), $urandom_range(4095), $urandom_range(65535),
			$urandom_range(65535));
		run_random(1050);

		drain();
		repeat (4) @(negedge clk);
		if (error_count == 0 && results_pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Run time limit
	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/dtg_pkg.sv
src/double_tap_gesture_detector.sv
src/dtg_checker.sv
tb/dtg_checker.sv
tb/tb.sv
